// ----- hdl/ple_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared widths, request and status codes, and the controller/datapath
// interface types of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 9;
    localparam int LEN_W        = 5;
    localparam int REQ_W        = 3;
    localparam int STAT_W       = 2;
    localparam int CAPACITY_DEF = 16;

    localparam int IN_DATA_W  = 48;  // item_value + position, padded to bytes
    localparam int OUT_DATA_W = 40;  // element + length, padded to bytes

    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DISPLAY   = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    typedef struct packed {
        logic exec;        // run a non-display request or an empty-list display, load its result
        logic start_disp;  // load first display element, rotate chain
        logic step_disp;   // load next display element, rotate chain
    } cmd_t;

    typedef struct packed {
        logic req_disp;    // incoming request is a display
        logic occ_zero;    // list is empty
        logic single;      // list holds one element
        logic step_last;   // next display step emits the final element
    } sts_t;

endpackage
`default_nettype wire

// ----- hdl/ple_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ctrl
// Controller: input handshake, display sequencing and output valid.
// ----------------------------------------------------------------------------
module ple_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire ple_pkg::sts_t sts,
    output ple_pkg::cmd_t      cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_DISP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_load;
    logic   accept;
    logic   load;

    always_comb
    begin
        can_load       = !out_valid_reg || m_tready;
        s_tready       = (state_reg == ST_IDLE) && can_load;
        accept         = s_tvalid && s_tready;
        cmd.exec       = accept && !(sts.req_disp && !sts.occ_zero);
        cmd.start_disp = accept && sts.req_disp && !sts.occ_zero;
        cmd.step_disp  = (state_reg == ST_DISP) && can_load;
        load           = cmd.exec || cmd.start_disp || cmd.step_disp;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start_disp && !sts.single)
                begin
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (cmd.step_disp && sts.step_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// ----- hdl/ple_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_datapath
// Shifting cell chain, occupancy, request decode and output payload register.
// ----------------------------------------------------------------------------
module ple_datapath
#(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [ple_pkg::REQ_W-1:0]    req_type,
    input  wire logic [ple_pkg::DATA_W-1:0]   item_value,
    input  wire logic [ple_pkg::POS_W-1:0]    position,
    input  wire ple_pkg::cmd_t                cmd,
    output ple_pkg::sts_t                     sts,
    output logic [ple_pkg::STAT_W-1:0]        status,
    output logic [ple_pkg::DATA_W-1:0]        element,
    output logic [ple_pkg::LEN_W-1:0]         length,
    output logic                              last
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CW    = ple_pkg::POS_W + 1;

    typedef enum logic [1:0] {
        MODE_KEEP,
        MODE_INS,
        MODE_DEL,
        MODE_ROT
    } mode_t;

    logic [ple_pkg::DATA_W-1:0] cells_reg [CAPACITY];
    logic [ple_pkg::DATA_W-1:0] cells_next [CAPACITY];
    logic [OCC_W-1:0]           occ_reg, occ_next, occ_upd;
    logic [OCC_W-1:0]           cnt_reg, cnt_next;
    logic [ple_pkg::STAT_W-1:0] status_reg, status_next, dec_status;
    logic [ple_pkg::DATA_W-1:0] element_reg, element_next;
    logic [ple_pkg::LEN_W-1:0]  length_reg, length_next;
    logic                       last_reg, last_next;
    logic [CW-1:0]              occ_w, pos_eff, idx;
    mode_t                      dec_mode, mode;
    logic                       load;

    // request decode
    always_comb
    begin
        occ_w      = CW'(occ_reg);
        pos_eff    = CW'(position);
        dec_status = ple_pkg::STAT_OK;
        dec_mode   = MODE_KEEP;
        occ_upd    = occ_reg;
        case (req_type)
            ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_BACK, ple_pkg::REQ_INS_POS:
            begin
                if (req_type == ple_pkg::REQ_INS_FRONT)
                begin
                    pos_eff = CW'(1);
                end
                else if (req_type == ple_pkg::REQ_INS_BACK)
                begin
                    pos_eff = occ_w + CW'(1);
                end
                if (pos_eff == '0 || pos_eff > occ_w + CW'(1))
                begin
                    dec_status = ple_pkg::STAT_BADPOS;
                end
                else if (occ_w >= CW'(CAPACITY))
                begin
                    dec_status = ple_pkg::STAT_FULL;
                end
                else
                begin
                    dec_mode = MODE_INS;
                    occ_upd  = occ_reg + OCC_W'(1);
                end
            end
            ple_pkg::REQ_DEL_FRONT, ple_pkg::REQ_DEL_BACK, ple_pkg::REQ_DEL_POS:
            begin
                if (req_type == ple_pkg::REQ_DEL_FRONT)
                begin
                    pos_eff = CW'(1);
                end
                else if (req_type == ple_pkg::REQ_DEL_BACK)
                begin
                    pos_eff = occ_w;
                end
                if (occ_reg == '0)
                begin
                    dec_status = ple_pkg::STAT_EMPTY;
                end
                else if (pos_eff == '0 || pos_eff > occ_w)
                begin
                    dec_status = ple_pkg::STAT_BADPOS;
                end
                else
                begin
                    dec_mode = MODE_DEL;
                    occ_upd  = occ_reg - OCC_W'(1);
                end
            end
            ple_pkg::REQ_DISPLAY:
            begin
                if (occ_reg == '0)
                begin
                    dec_status = ple_pkg::STAT_EMPTY;
                end
            end
            default:
            begin
                dec_status = ple_pkg::STAT_OK;
            end
        endcase
        idx = pos_eff - CW'(1);

        if (cmd.exec)
        begin
            mode = dec_mode;
        end
        else if (cmd.start_disp || cmd.step_disp)
        begin
            mode = MODE_ROT;
        end
        else
        begin
            mode = MODE_KEEP;
        end
    end

    // shifting chain: each cell looks only at itself, its neighbors, the head and the input value
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ple_pkg::DATA_W-1:0] below;
        logic [ple_pkg::DATA_W-1:0] above;

        if (g == 0)
        begin : g_first
            assign below = item_value;
        end
        else
        begin : g_mid
            assign below = cells_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_end
            assign above = cells_reg[g];
        end
        else
        begin : g_inner
            assign above = cells_reg[g+1];
        end

        always_comb
        begin
            case (mode)
                MODE_INS:
                begin
                    if (CW'(g) < idx)
                    begin
                        cells_next[g] = cells_reg[g];
                    end
                    else if (CW'(g) == idx)
                    begin
                        cells_next[g] = item_value;
                    end
                    else
                    begin
                        cells_next[g] = below;
                    end
                end
                MODE_DEL:
                begin
                    cells_next[g] = (CW'(g) < idx) ? cells_reg[g] : above;
                end
                MODE_ROT:
                begin
                    cells_next[g] = (CW'(g) == occ_w - CW'(1)) ? cells_reg[0] : above;
                end
                default:
                begin
                    cells_next[g] = cells_reg[g];
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            cells_reg[g] <= cells_next[g];
        end
    end

    always_comb
    begin
        sts.req_disp  = (req_type == ple_pkg::REQ_DISPLAY);
        sts.occ_zero  = (occ_reg == '0);
        sts.single    = (occ_reg == OCC_W'(1));
        sts.step_last = (cnt_reg == occ_reg - OCC_W'(1));

        load         = cmd.exec || cmd.start_disp || cmd.step_disp;
        occ_next     = cmd.exec ? occ_upd : occ_reg;
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        element_next = element_reg;
        length_next  = length_reg;
        last_next    = last_reg;
        if (cmd.exec)
        begin
            status_next  = dec_status;
            element_next = '0;
            length_next  = ple_pkg::LEN_W'(occ_upd);
            last_next    = 1'b1;
        end
        else if (cmd.start_disp || cmd.step_disp)
        begin
            cnt_next     = cmd.start_disp ? OCC_W'(1) : cnt_reg + OCC_W'(1);
            status_next  = ple_pkg::STAT_OK;
            element_next = cells_reg[0];
            length_next  = ple_pkg::LEN_W'(occ_reg);
            last_next    = cmd.start_disp ? sts.single : sts.step_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= status_next;
            element_reg <= element_next;
            length_reg  <= length_next;
            last_reg    <= last_next;
        end
    end

    assign status  = status_reg;
    assign element = element_reg;
    assign length  = length_reg;
    assign last    = last_reg;

endmodule
`default_nettype wire

// ----- hdl/positional_list_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with positional insert and
// delete and a streamed display.
//
// Input channel s_*: one transaction per request; s_tuser carries the request
// type, s_tdata the value and the 1-based position. Output channel m_*: one
// transaction per result; m_tuser carries the status, m_tdata the element and
// the element count after the request, m_tlast marks the final result.
// Insert, delete and unused codes: one result, registered at acceptance;
// a new request is taken every cycle while results are drained.
// Display: one result per element (one with status empty on an empty list),
// one per cycle while results are drained, from the head of a rotating cell
// chain; no request is taken until the last element has been loaded into the
// output register. The first result appears in the cycle after acceptance.
// Reset empties the list; cell contents are not cleared. When m_tready is
// low a loaded output register holds its transaction and s_tready stays low
// until that transaction is taken.
// ----------------------------------------------------------------------------
module positional_list_engine
#(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ple_pkg::IN_DATA_W-1:0]     s_tdata,   // item_value, position
    input  wire logic [ple_pkg::REQ_W-1:0]         s_tuser,   // req_type
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ple_pkg::OUT_DATA_W-1:0]         m_tdata,   // element, length
    output logic [ple_pkg::STAT_W-1:0]             m_tuser,   // status
    output logic                                   m_tlast
);

    ple_pkg::cmd_t              cmd;
    ple_pkg::sts_t              sts;
    logic [ple_pkg::DATA_W-1:0] element;
    logic [ple_pkg::LEN_W-1:0]  length;

    ple_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (s_tuser),
        .item_value (s_tdata[ple_pkg::DATA_W-1:0]),
        .position   (s_tdata[ple_pkg::DATA_W +: ple_pkg::POS_W]),
        .cmd        (cmd),
        .sts        (sts),
        .status     (m_tuser),
        .element    (element),
        .length     (length),
        .last       (m_tlast)
    );

    assign m_tdata = {
        {(ple_pkg::OUT_DATA_W - ple_pkg::DATA_W - ple_pkg::LEN_W){1'b0}},
        length,
        element
    };

endmodule
`default_nettype wire
